// File: rtl/sps_pkg.sv
`default_nettype none

package sps_pkg;

  // Default width of the position and goal counters.
  localparam int DEF_POS_WIDTH = 32;

  // Fixed widths of the transaction fields.
  localparam int FIELD_POS_W = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 2;

  // Level of an idle step or direction pin.
  localparam logic PIN_LOW = 1'b0;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_POSITION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_POSITION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_DIR   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_ENABLE   = 2'd3;

  // Configuration reset values.
  localparam logic signed [FIELD_POS_W-1:0] MIN_POSITION_RST = 32'sd0;
  localparam logic signed [FIELD_POS_W-1:0] MAX_POSITION_RST = 32'sd65535;

  typedef enum logic [2:0] {
    ACT_TICK     = 3'd0,
    ACT_MOVE_TO  = 3'd1,
    ACT_SET_ZERO = 3'd2,
    ACT_STOP     = 3'd3,
    ACT_ENABLE   = 3'd4,
    ACT_DISABLE  = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    ST_DEST_REACHED = 3'd0,
    ST_MOVING       = 3'd1,
    ST_BLOCKED_MIN  = 3'd2,
    ST_BLOCKED_MAX  = 3'd3,
    ST_BAD_BOUNDS   = 3'd4
  } status_t;

  typedef struct packed {
    logic [2:0]                    action;
    logic signed [FIELD_POS_W-1:0] target_position;
  } in_item_t;

  typedef struct packed {
    logic                          step_level;
    logic                          dir_level;
    logic                          stepped;
    logic signed [FIELD_POS_W-1:0] position;
    logic [2:0]                    status;
    logic                          at_target;
  } out_item_t;

  typedef struct packed {
    logic signed [FIELD_POS_W-1:0] min_position;
    logic signed [FIELD_POS_W-1:0] max_position;
    logic                          invert_dir;
    logic                          use_enable;
  } cfg_t;

endpackage

`default_nettype wire

// File: rtl/sps_cfg_regs.sv
`default_nettype none

module sps_cfg_regs (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [sps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [sps_pkg::CFG_DATA_W-1:0]      cfg_data,
  output sps_pkg::cfg_t                            cfg_o
);

  sps_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_position <= sps_pkg::MIN_POSITION_RST;
      cfg_r.max_position <= sps_pkg::MAX_POSITION_RST;
      cfg_r.invert_dir   <= 1'b0;
      cfg_r.use_enable   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sps_pkg::CFG_MIN_POSITION: cfg_r.min_position <= $signed(cfg_data);
        sps_pkg::CFG_MAX_POSITION: cfg_r.max_position <= $signed(cfg_data);
        sps_pkg::CFG_INVERT_DIR:   cfg_r.invert_dir   <= cfg_data[0];
        sps_pkg::CFG_USE_ENABLE:   cfg_r.use_enable   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule

`default_nettype wire

// File: rtl/sps_core.sv
`default_nettype none

module sps_core #(
  parameter int POS_WIDTH = sps_pkg::DEF_POS_WIDTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              fire,
  input  wire sps_pkg::in_item_t item_i,
  input  wire sps_pkg::cfg_t     cfg_i,
  output sps_pkg::out_item_t     res_o
);

  // Compare width covers both the position counter and the 32-bit bounds.
  localparam int CW = (POS_WIDTH > sps_pkg::FIELD_POS_W) ? POS_WIDTH : sps_pkg::FIELD_POS_W;

  logic signed [POS_WIDTH-1:0] cur_r, cur_nxt;
  logic signed [POS_WIDTH-1:0] goal_r, goal_nxt;
  logic                        toggle_r, toggle_nxt;
  logic                        step_pin_r, step_pin_nxt;
  logic                        dir_pin_r, dir_pin_nxt;
  logic                        enabled_r, enabled_nxt;
  sps_pkg::status_t            status_r, status_nxt;
  logic                        stepped;

  logic signed [CW-1:0] cur_x, goal_x, min_x, max_x;
  logic                 gated, bad_bounds, at_goal, up;
  logic                 in_range, at_min, at_max, goal_above_min, goal_below_max;
  logic                 do_step;

  assign cur_x  = CW'(cur_r);
  assign goal_x = CW'(goal_r);
  assign min_x  = CW'($signed(cfg_i.min_position));
  assign max_x  = CW'($signed(cfg_i.max_position));

  assign gated          = cfg_i.use_enable && !enabled_r;
  assign bad_bounds     = !(min_x < max_x);
  assign at_goal        = (goal_r == cur_r);
  assign up             = (goal_r > cur_r);
  assign in_range       = (cur_x > min_x) && (cur_x < max_x);
  assign at_min         = (cur_x == min_x);
  assign at_max         = (cur_x == max_x);
  assign goal_above_min = (goal_x > min_x);
  assign goal_below_max = (goal_x < max_x);

  always_comb begin
    cur_nxt      = cur_r;
    goal_nxt     = goal_r;
    toggle_nxt   = toggle_r;
    step_pin_nxt = step_pin_r;
    dir_pin_nxt  = dir_pin_r;
    enabled_nxt  = enabled_r;
    status_nxt   = status_r;
    do_step      = 1'b0;

    unique case (item_i.action)
      sps_pkg::ACT_TICK: begin
        if (!gated) begin
          if (bad_bounds) begin
            status_nxt = sps_pkg::ST_BAD_BOUNDS;
          end else if (at_goal) begin
            status_nxt = sps_pkg::ST_DEST_REACHED;
          end else begin
            dir_pin_nxt = (up == cfg_i.invert_dir);
            if (in_range) begin
              do_step    = 1'b1;
              status_nxt = sps_pkg::ST_MOVING;
            end else if (at_min) begin
              if (goal_above_min) begin
                do_step    = 1'b1;
                status_nxt = sps_pkg::ST_MOVING;
              end else begin
                status_nxt = sps_pkg::ST_BLOCKED_MIN;
              end
            end else if (at_max) begin
              if (goal_below_max) begin
                do_step    = 1'b1;
                status_nxt = sps_pkg::ST_MOVING;
              end else begin
                status_nxt = sps_pkg::ST_BLOCKED_MAX;
              end
            end
          end
        end
      end
      sps_pkg::ACT_MOVE_TO:  goal_nxt = POS_WIDTH'($signed(item_i.target_position));
      sps_pkg::ACT_SET_ZERO: begin
        cur_nxt  = '0;
        goal_nxt = '0;
      end
      sps_pkg::ACT_STOP:     goal_nxt = cur_r;
      sps_pkg::ACT_ENABLE:   enabled_nxt = cfg_i.use_enable;
      sps_pkg::ACT_DISABLE:  enabled_nxt = !cfg_i.use_enable;
      default: ;
    endcase

    // A step always heads toward the goal, also when leaving a bound.
    if (do_step) begin
      step_pin_nxt = toggle_r;
      toggle_nxt   = !toggle_r;
      cur_nxt      = up ? (cur_r + POS_WIDTH'(1)) : (cur_r - POS_WIDTH'(1));
    end
  end

  assign stepped = do_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r      <= '0;
      goal_r     <= '0;
      toggle_r   <= 1'b0;
      step_pin_r <= sps_pkg::PIN_LOW;
      dir_pin_r  <= sps_pkg::PIN_LOW;
      enabled_r  <= 1'b0;
      status_r   <= sps_pkg::ST_DEST_REACHED;
    end else if (fire) begin
      cur_r      <= cur_nxt;
      goal_r     <= goal_nxt;
      toggle_r   <= toggle_nxt;
      step_pin_r <= step_pin_nxt;
      dir_pin_r  <= dir_pin_nxt;
      enabled_r  <= enabled_nxt;
      status_r   <= status_nxt;
    end
  end

  always_comb begin
    res_o.step_level = step_pin_nxt;
    res_o.dir_level  = dir_pin_nxt;
    res_o.stepped    = stepped;
    res_o.position   = sps_pkg::FIELD_POS_W'(cur_nxt);
    res_o.status     = status_nxt;
    res_o.at_target  = (cur_nxt == goal_nxt);
  end

endmodule

`default_nettype wire

// File: rtl/stepper_position_stepper_top.sv
// Step/direction position controller, one result transaction per input transaction.
// The result passes from the input register through the update logic into the result
// register. Throughput: one transaction per cycle while the output is not stalled, as the
// position and pin state are updated as each transaction is processed.
// Reset (rst_n, synchronous, active low) clears position, goal, pins, enable and status,
// and loads the bound and flag registers with their defaults.
`default_nettype none

module stepper_position_stepper_top #(
  parameter int POS_WIDTH = sps_pkg::DEF_POS_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,

  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire sps_pkg::in_item_t              in_item,

  output logic                                out_valid,
  input  wire logic                           out_stall,
  output sps_pkg::out_item_t                  out_item,

  input  wire logic                           cfg_we,
  input  wire logic [sps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sps_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Input register holding one accepted transaction.
  logic               s1_valid_r;
  sps_pkg::in_item_t  s1_item_r;

  // Result register; it stays loaded until the downstream side takes it.
  logic               out_valid_r;
  sps_pkg::out_item_t out_item_r;

  sps_pkg::cfg_t      cfg;
  sps_pkg::out_item_t res;

  logic advance;
  logic fire;
  logic in_accept;

  // The result register can take a new result when it is empty or being drained.
  assign advance   = !out_valid_r || !out_stall;
  // The held transaction is processed and its state update committed in this cycle.
  assign fire      = s1_valid_r && advance;
  // The input register refills in the same cycle it drains, so a full pipe
  // stalls only when the result side is stalled.
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_item;
    end
  end

  sps_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  // Motor state and the per-action update logic.
  sps_core #(
    .POS_WIDTH (POS_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item_i (s1_item_r),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire
